// File: rtl/mrr_pkg.sv
// Shared types, constants and helper functions for the mixed-radix rank unit.
// No dependencies; every other file but the checker refers to this package by scoped names.
package mrr_pkg;

  localparam int unsigned MAX_DIGITS   = 4;
  localparam int unsigned DIGIT_BITS   = 8;
  localparam int unsigned RANK_BITS    = 32;
  localparam int unsigned RADIX_BITS   = 9;
  localparam int unsigned NV_BITS      = 3;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned MASK_BITS    = 4;

  // Division cells per digit: four quotient bits are resolved in each cell.
  localparam int unsigned BITS_PER_CELL  = 4;
  localparam int unsigned CELLS_PER_DIG  = RANK_BITS / BITS_PER_CELL;
  localparam int unsigned DIV_CELLS      = CELLS_PER_DIG * MAX_DIGITS;
  localparam int unsigned STAGES         = DIV_CELLS + 1 + MAX_DIGITS;

  // Operation codes.
  localparam logic [1:0] MODE_RANK   = 2'd0;
  localparam logic [1:0] MODE_UNRANK = 2'd1;
  localparam logic [1:0] MODE_NEXT   = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] REG_NUM_VARS = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DOMAIN0  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_DOMAIN1  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DOMAIN2  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_DOMAIN3  = 3'd4;

  localparam logic [RADIX_BITS-1:0] MAX_RADIX = 9'd256;

  typedef logic [MAX_DIGITS-1:0][DIGIT_BITS-1:0] digits_t;
  typedef logic [MAX_DIGITS-1:0][RADIX_BITS-1:0] radices_t;

  // One transaction as it travels down the chain of cells.
  typedef struct packed {
    logic [1:0]            mode;
    logic [MASK_BITS-1:0]  mask;
    logic [RANK_BITS-1:0]  work;  // dividend/quotient, later the Horner accumulator
    logic [DIGIT_BITS-1:0] rem;   // running remainder of the current digit
    digits_t               din;   // digits supplied for ranking
    digits_t               dig;   // unranked, then rewritten digits
    logic                  adv;
  } item_t;

  // Number of digits in use, clamped to 1..MAX_DIGITS.
  function automatic logic [NV_BITS-1:0] nv_clamp(input logic [NV_BITS-1:0] nv);
    logic [NV_BITS-1:0] res;
    res = nv;
    if (nv == '0) res = NV_BITS'(1);
    if (nv > NV_BITS'(MAX_DIGITS)) res = NV_BITS'(MAX_DIGITS);
    return res;
  endfunction

  // Radix as used by the arithmetic: unused digits behave as radix one.
  function automatic logic [RADIX_BITS-1:0] eff_radix(input logic [RADIX_BITS-1:0] dom,
                                                      input logic used);
    logic [RADIX_BITS-1:0] res;
    res = dom;
    if (dom == '0) res = RADIX_BITS'(1);
    if (dom > MAX_RADIX) res = MAX_RADIX;
    if (!used) res = RADIX_BITS'(1);
    return res;
  endfunction

endpackage

// File: rtl/mixed_radix_rank_unit_core.sv
// Top level of the mixed-radix rank unit: configuration registers and the cell chain.
// Depends on mrr_pkg, mrr_div_cell, mrr_step_cell and mrr_mac_cell.
//
// The unit takes one transaction per clock when the output is not stalled. Every
// transaction walks a chain of 37 cells: 32 division cells (eight per digit,
// four quotient bits each) split the rank into its digits and the high part
// above them, one cell rewrites the digits for ranking or for the masked
// increment, and four multiply-add cells rebuild the rank from the most
// significant digit down. Each cell holds its own stage register with a valid
// bit, so bubbles close up while the output is stalled. Configuration must
// only be written while no transaction is in flight.
module mixed_radix_rank_unit_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mrr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [mrr_pkg::RADIX_BITS-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_mode,
  input  logic [mrr_pkg::RANK_BITS-1:0]     in_rank_in,
  input  logic [mrr_pkg::DIGIT_BITS-1:0]    in_digit0_in,
  input  logic [mrr_pkg::DIGIT_BITS-1:0]    in_digit1_in,
  input  logic [mrr_pkg::DIGIT_BITS-1:0]    in_digit2_in,
  input  logic [mrr_pkg::DIGIT_BITS-1:0]    in_digit3_in,
  input  logic [mrr_pkg::MASK_BITS-1:0]     in_mutable_mask,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mrr_pkg::RANK_BITS-1:0]     out_rank_out,
  output logic [mrr_pkg::DIGIT_BITS-1:0]    out_digit0_out,
  output logic [mrr_pkg::DIGIT_BITS-1:0]    out_digit1_out,
  output logic [mrr_pkg::DIGIT_BITS-1:0]    out_digit2_out,
  output logic [mrr_pkg::DIGIT_BITS-1:0]    out_digit3_out,
  output logic                              out_advanced
);

  localparam int unsigned NODES = mrr_pkg::STAGES + 1;

  logic [mrr_pkg::NV_BITS-1:0]    num_vars_r;
  mrr_pkg::radices_t              dom_r;
  logic [mrr_pkg::NV_BITS-1:0]    nv_eff;
  logic [mrr_pkg::MAX_DIGITS-1:0] used;
  mrr_pkg::radices_t              radix;

  logic                node_vld [NODES];
  mrr_pkg::item_t      node_item[NODES];
  logic                node_rdy [NODES];
  mrr_pkg::item_t      out_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vars_r <= mrr_pkg::NV_BITS'(mrr_pkg::MAX_DIGITS);
      for (int j = 0; j < mrr_pkg::MAX_DIGITS; j++) begin
        dom_r[j] <= mrr_pkg::RADIX_BITS'(2);
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        mrr_pkg::REG_NUM_VARS: num_vars_r <= cfg_wdata[mrr_pkg::NV_BITS-1:0];
        mrr_pkg::REG_DOMAIN0:  dom_r[0]   <= cfg_wdata;
        mrr_pkg::REG_DOMAIN1:  dom_r[1]   <= cfg_wdata;
        mrr_pkg::REG_DOMAIN2:  dom_r[2]   <= cfg_wdata;
        mrr_pkg::REG_DOMAIN3:  dom_r[3]   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective radices; digits beyond the count in use act as radix one.
  always_comb begin
    nv_eff = mrr_pkg::nv_clamp(num_vars_r);
    for (int j = 0; j < mrr_pkg::MAX_DIGITS; j++) begin
      used[j]  = (mrr_pkg::NV_BITS'(j) < nv_eff);
      radix[j] = mrr_pkg::eff_radix(dom_r[j], used[j]);
    end
  end

  // Incoming transaction.
  always_comb begin
    node_item[0]        = '0;
    node_item[0].mode   = in_mode;
    node_item[0].mask   = in_mutable_mask;
    node_item[0].work   = in_rank_in;
    node_item[0].din[0] = in_digit0_in;
    node_item[0].din[1] = in_digit1_in;
    node_item[0].din[2] = in_digit2_in;
    node_item[0].din[3] = in_digit3_in;
  end

  assign node_vld[0] = in_valid;
  assign in_stall    = !node_rdy[0];
  assign node_rdy[NODES-1] = !out_stall;

  // Division cells; a new digit starts with its remainder cleared and the
  // finished remainder of the previous digit stored.
  for (genvar k = 0; k < mrr_pkg::DIV_CELLS; k++) begin : g_div
    localparam int unsigned PREV = (k > 0) ? (k / mrr_pkg::CELLS_PER_DIG) - 1 : 0;
    mrr_pkg::item_t cell_in;
    always_comb begin
      cell_in = node_item[k];
      if ((k % mrr_pkg::CELLS_PER_DIG) == 0) begin
        cell_in.rem = '0;
        if (k > 0) begin
          cell_in.dig[PREV] = node_item[k].rem;
        end
      end
    end
    mrr_div_cell u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (node_vld[k]),
      .in_item  (cell_in),
      .radix    (radix[k / mrr_pkg::CELLS_PER_DIG]),
      .nxt_rdy  (node_rdy[k+1]),
      .rdy      (node_rdy[k]),
      .out_vld  (node_vld[k+1]),
      .out_item (node_item[k+1])
    );
  end

  // Digit rewrite cell, taking the last remainder as the top digit.
  mrr_pkg::item_t step_in;
  always_comb begin
    step_in = node_item[mrr_pkg::DIV_CELLS];
    step_in.dig[mrr_pkg::MAX_DIGITS-1] = node_item[mrr_pkg::DIV_CELLS].rem;
  end

  mrr_step_cell u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (node_vld[mrr_pkg::DIV_CELLS]),
    .in_item  (step_in),
    .radix    (radix),
    .used     (used),
    .nxt_rdy  (node_rdy[mrr_pkg::DIV_CELLS+1]),
    .rdy      (node_rdy[mrr_pkg::DIV_CELLS]),
    .out_vld  (node_vld[mrr_pkg::DIV_CELLS+1]),
    .out_item (node_item[mrr_pkg::DIV_CELLS+1])
  );

  // Horner cells, most significant digit first.
  for (genvar m = 0; m < mrr_pkg::MAX_DIGITS; m++) begin : g_mac
    localparam int unsigned N = mrr_pkg::DIV_CELLS + 1 + m;
    mrr_mac_cell u_mac (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (node_vld[N]),
      .in_item  (node_item[N]),
      .radix    (radix[mrr_pkg::MAX_DIGITS-1-m]),
      .digit    (node_item[N].dig[mrr_pkg::MAX_DIGITS-1-m]),
      .nxt_rdy  (node_rdy[N+1]),
      .rdy      (node_rdy[N]),
      .out_vld  (node_vld[N+1]),
      .out_item (node_item[N+1])
    );
  end

  // Result fields, zeroed where the operation does not produce them.
  assign out_item  = node_item[NODES-1];
  assign out_valid = node_vld[NODES-1];

  always_comb begin
    out_rank_out   = '0;
    out_digit0_out = '0;
    out_digit1_out = '0;
    out_digit2_out = '0;
    out_digit3_out = '0;
    out_advanced   = 1'b0;
    unique case (out_item.mode)
      mrr_pkg::MODE_RANK: out_rank_out = out_item.work;
      mrr_pkg::MODE_UNRANK: begin
        out_digit0_out = out_item.dig[0];
        out_digit1_out = out_item.dig[1];
        out_digit2_out = out_item.dig[2];
        out_digit3_out = out_item.dig[3];
      end
      mrr_pkg::MODE_NEXT: begin
        out_rank_out = out_item.work;
        out_advanced = out_item.adv;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/mrr_div_cell.sv
// Division cell: resolves four quotient bits of rank / radix per transaction.
// Depends on mrr_pkg.
module mrr_div_cell (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  input  mrr_pkg::item_t               in_item,
  input  logic [mrr_pkg::RADIX_BITS-1:0] radix,
  input  logic                         nxt_rdy,
  output logic                         rdy,
  output logic                         out_vld,
  output mrr_pkg::item_t               out_item
);

  logic           vld_r;
  mrr_pkg::item_t item_r;
  mrr_pkg::item_t item_nxt;

  // Restoring division, one quotient bit per step.
  always_comb begin
    logic [mrr_pkg::RADIX_BITS-1:0] t;
    logic                           ge;
    item_nxt = in_item;
    for (int s = 0; s < mrr_pkg::BITS_PER_CELL; s++) begin
      t  = {item_nxt.rem, item_nxt.work[mrr_pkg::RANK_BITS-1]};
      ge = (t >= radix);
      item_nxt.work = {item_nxt.work[mrr_pkg::RANK_BITS-2:0], ge};
      item_nxt.rem  = ge ? mrr_pkg::DIGIT_BITS'(t - radix) : t[mrr_pkg::DIGIT_BITS-1:0];
    end
  end

  assign rdy = !vld_r || nxt_rdy;

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_vld) begin
      item_r <= item_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule

// File: rtl/mrr_step_cell.sv
// Digit rewrite cell: selects ranking digits or advances the masked odometer.
// Depends on mrr_pkg.
module mrr_step_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_vld,
  input  mrr_pkg::item_t                  in_item,
  input  mrr_pkg::radices_t               radix,
  input  logic [mrr_pkg::MAX_DIGITS-1:0]  used,
  input  logic                            nxt_rdy,
  output logic                            rdy,
  output logic                            out_vld,
  output mrr_pkg::item_t                  out_item
);

  logic           vld_r;
  mrr_pkg::item_t item_r;
  mrr_pkg::item_t item_nxt;

  // Ranking takes the supplied digits over a zero high part; the next-rank
  // operation bumps the first masked digit that has room and clears those
  // passed on the way.
  always_comb begin
    logic found;
    item_nxt = in_item;
    found    = 1'b0;
    case (in_item.mode)
      mrr_pkg::MODE_RANK: begin
        item_nxt.work = '0;
        for (int j = 0; j < mrr_pkg::MAX_DIGITS; j++) begin
          item_nxt.dig[j] = used[j] ? in_item.din[j] : '0;
        end
      end
      mrr_pkg::MODE_NEXT: begin
        for (int j = 0; j < mrr_pkg::MAX_DIGITS; j++) begin
          if (in_item.mask[j] && used[j] && !found) begin
            if ({1'b0, in_item.dig[j]} + mrr_pkg::RADIX_BITS'(1) < radix[j]) begin
              item_nxt.dig[j] = in_item.dig[j] + mrr_pkg::DIGIT_BITS'(1);
              found = 1'b1;
            end else begin
              item_nxt.dig[j] = '0;
            end
          end
        end
      end
      default: ;
    endcase
    item_nxt.adv = found;
  end

  assign rdy = !vld_r || nxt_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_vld) begin
      item_r <= item_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule

// File: rtl/mrr_mac_cell.sv
// Horner cell: accumulator times radix plus one digit, modulo 2^32.
// Depends on mrr_pkg.
module mrr_mac_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  mrr_pkg::item_t                 in_item,
  input  logic [mrr_pkg::RADIX_BITS-1:0] radix,
  input  logic [mrr_pkg::DIGIT_BITS-1:0] digit,
  input  logic                           nxt_rdy,
  output logic                           rdy,
  output logic                           out_vld,
  output mrr_pkg::item_t                 out_item
);

  logic           vld_r;
  mrr_pkg::item_t item_r;
  mrr_pkg::item_t item_nxt;

  // One multiply and add, wrapping at the rank width.
  always_comb begin
    item_nxt      = in_item;
    item_nxt.work = mrr_pkg::RANK_BITS'(in_item.work * radix)
                    + {{(mrr_pkg::RANK_BITS-mrr_pkg::DIGIT_BITS){1'b0}}, digit};
  end

  assign rdy = !vld_r || nxt_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy && in_vld) begin
      item_r <= item_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule

// File: rtl/mrr_checker.sv
// Port-level checker for the mixed-radix rank unit, bound to the top level.
// Depends only on the ports of mixed_radix_rank_unit_core.
module mrr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_rank_out,
  input logic [7:0]  out_digit0_out,
  input logic [7:0]  out_digit1_out,
  input logic [7:0]  out_digit2_out,
  input logic [7:0]  out_digit3_out,
  input logic        out_advanced
);

  // A stalled result holds its rank and advance flag until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rank_out) && $stable(out_advanced))
    else $error("stalled result changed");

  // Nothing comes out of an empty chain straight after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // Unranked digits only appear on unrank transactions, which carry no rank.
  a_digits_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_digit0_out != 8'd0 || out_digit1_out != 8'd0 ||
                  out_digit2_out != 8'd0 || out_digit3_out != 8'd0)
    |-> out_rank_out == 32'd0 && !out_advanced)
    else $error("digits mixed with rank result");

  // An advance is a next-rank result and shows no digits.
  a_adv_no_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_advanced |-> out_digit0_out == 8'd0 && out_digit1_out == 8'd0 &&
                                  out_digit2_out == 8'd0 && out_digit3_out == 8'd0)
    else $error("advance flag with digits");

endmodule

bind mixed_radix_rank_unit_core mrr_checker u_mrr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_rank_out   (out_rank_out),
  .out_digit0_out (out_digit0_out),
  .out_digit1_out (out_digit1_out),
  .out_digit2_out (out_digit2_out),
  .out_digit3_out (out_digit3_out),
  .out_advanced   (out_advanced)
);

// File: verif/tb_mixed_radix_rank_unit_core.sv
// Self-checking testbench for the mixed-radix rank unit: ranking, unranking and masked
// increment checked against a behavioural predictor under several radix settings.
// Depends on mrr_pkg and mixed_radix_rank_unit_core.
module tb_mixed_radix_rank_unit_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNDEF = 2'd3;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct {
    logic [1:0]                         mode;
    logic [mrr_pkg::RANK_BITS-1:0]      rank;
    logic [mrr_pkg::DIGIT_BITS-1:0]     dig [mrr_pkg::MAX_DIGITS];
    logic [mrr_pkg::MASK_BITS-1:0]      mask;
  } rank_request_t;

  typedef struct {
    logic [mrr_pkg::RANK_BITS-1:0]      rank;
    logic [mrr_pkg::DIGIT_BITS-1:0]     dig [mrr_pkg::MAX_DIGITS];
    logic                               adv;
  } rank_answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [mrr_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [mrr_pkg::RADIX_BITS-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = '0;
  logic [mrr_pkg::RANK_BITS-1:0] in_rank_in = '0;
  logic [mrr_pkg::DIGIT_BITS-1:0] in_digit0_in = '0, in_digit1_in = '0;
  logic [mrr_pkg::DIGIT_BITS-1:0] in_digit2_in = '0, in_digit3_in = '0;
  logic [mrr_pkg::MASK_BITS-1:0] in_mutable_mask = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [mrr_pkg::RANK_BITS-1:0] out_rank_out;
  logic [mrr_pkg::DIGIT_BITS-1:0] out_digit0_out, out_digit1_out;
  logic [mrr_pkg::DIGIT_BITS-1:0] out_digit2_out, out_digit3_out;
  logic out_advanced;

  // Shadow copy of the configuration registers.
  logic [mrr_pkg::NV_BITS-1:0] num_vars_shadow;
  logic [mrr_pkg::RADIX_BITS-1:0] domain_shadow [mrr_pkg::MAX_DIGITS];

  rank_request_t pending_requests[$];
  rank_answer_t expected_answers[$];
  rank_request_t current_request;
  bit idling_enabled = 1'b1;
  int unsigned send_gap = 0, recv_gap = 0;
  int unsigned mismatches = 0, answers_seen = 0, requests_sent = 0, phases_run = 0;

  always #5 clk = ~clk;

  mixed_radix_rank_unit_core DUT (.*);

  // Number of digits in use and radix of each digit as the arithmetic sees it for a digit in use.
  function automatic int unsigned digits_in_use();
    int unsigned n;
    n = 32'(num_vars_shadow);
    if (n < 1) n = 1;
    if (n > mrr_pkg::MAX_DIGITS) n = mrr_pkg::MAX_DIGITS;
    return n;
  endfunction

  function automatic longint unsigned radix_at(int unsigned i);
    longint unsigned r;
    r = 64'(domain_shadow[i]);
    if (r == 0) r = 1;
    if (r > 256) r = 256;
    return r;
  endfunction

  // Expected answer for one request under the shadow configuration.
  function automatic rank_answer_t predict_answer(rank_request_t req);
    rank_answer_t ans;
    longint unsigned weight [mrr_pkg::MAX_DIGITS];
    longint unsigned cur, rk, r, v, sum;
    int unsigned n;
    bit done;
    n = digits_in_use();
    cur = 1;
    for (int i = 0; i < mrr_pkg::MAX_DIGITS; i++) begin
      weight[i] = cur;
      cur = (cur * radix_at(i)) & 64'hFFFF_FFFF;
      ans.dig[i] = '0;
    end
    ans.rank = '0;
    ans.adv = 1'b0;
    rk = 64'(req.rank);
    case (req.mode)
      mrr_pkg::MODE_RANK: begin
        sum = 0;
        for (int i = 0; i < n; i++) sum = (sum + req.dig[i] * weight[i]) & 64'hFFFF_FFFF;
        ans.rank = 32'(sum);
      end
      mrr_pkg::MODE_UNRANK: begin
        for (int i = 0; i < n; i++) ans.dig[i] = 8'((rk / weight[i]) % radix_at(i));
      end
      mrr_pkg::MODE_NEXT: begin
        done = 1'b0;
        for (int i = 0; i < n && !done; i++) begin
          if (req.mask[i]) begin
            r = radix_at(i);
            v = (rk / weight[i]) % r;
            if (v + 1 < r) begin
              rk = (rk + weight[i]) & 64'hFFFF_FFFF;
              done = 1'b1;
            end else begin
              rk = (rk - v * weight[i]) & 64'hFFFF_FFFF;
            end
          end
        end
        ans.rank = 32'(rk);
        ans.adv = done;
      end
      default: ;
    endcase
    return ans;
  endfunction

  // Sender: presents queued requests and records an expectation per accepted transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_answers.push_back(predict_answer(current_request));
        requests_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() > 0) begin
          current_request = pending_requests.pop_front();
          in_mode <= current_request.mode;
          in_rank_in <= current_request.rank;
          in_digit0_in <= current_request.dig[0];
          in_digit1_in <= current_request.dig[1];
          in_digit2_in <= current_request.dig[2];
          in_digit3_in <= current_request.dig[3];
          in_mutable_mask <= current_request.mask;
          in_valid <= 1'b1;
          if (idling_enabled && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Compares one field and reports the first few differences.
  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch in %s: expected %0h, got %0h", name, exp_v, act_v);
    end
  endfunction

  // Receiver: random stall bursts and a field-by-field comparison of each result.
  always @(posedge clk) begin
    rank_answer_t exp_a;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        answers_seen++;
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result with nothing outstanding");
        end else begin
          exp_a = expected_answers.pop_front();
          check_field("rank_out", exp_a.rank, out_rank_out);
          check_field("digit0_out", 32'(exp_a.dig[0]), 32'(out_digit0_out));
          check_field("digit1_out", 32'(exp_a.dig[1]), 32'(out_digit1_out));
          check_field("digit2_out", 32'(exp_a.dig[2]), 32'(out_digit2_out));
          check_field("digit3_out", 32'(exp_a.dig[3]), 32'(out_digit3_out));
          check_field("advanced", 32'(exp_a.adv), 32'(out_advanced));
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else if (idling_enabled && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Register write with a one-cycle write strobe; the shadow copy follows it.
  task automatic write_register(logic [mrr_pkg::CFG_IDX_BITS-1:0] idx,
                                logic [mrr_pkg::RADIX_BITS-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == mrr_pkg::REG_NUM_VARS) num_vars_shadow = val[mrr_pkg::NV_BITS-1:0];
    else domain_shadow[2'(idx - mrr_pkg::REG_DOMAIN0)] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(int unsigned nv, int unsigned d0, int unsigned d1,
                           int unsigned d2, int unsigned d3);
    write_register(mrr_pkg::REG_NUM_VARS, mrr_pkg::RADIX_BITS'(nv));
    write_register(mrr_pkg::REG_DOMAIN0, mrr_pkg::RADIX_BITS'(d0));
    write_register(mrr_pkg::REG_DOMAIN1, mrr_pkg::RADIX_BITS'(d1));
    write_register(mrr_pkg::REG_DOMAIN2, mrr_pkg::RADIX_BITS'(d2));
    write_register(mrr_pkg::REG_DOMAIN3, mrr_pkg::RADIX_BITS'(d3));
  endtask

  task automatic queue_request(logic [1:0] mode, logic [31:0] rank, logic [31:0] digs,
                               logic [3:0] mask);
    rank_request_t req;
    req.mode = mode;
    req.rank = rank;
    for (int i = 0; i < mrr_pkg::MAX_DIGITS; i++) req.dig[i] = digs[8*i +: 8];
    req.mask = mask;
    pending_requests.push_back(req);
  endtask

  // Random request: mostly digits inside their radices and ranks inside the space,
  // so that increments run through carries; the rest is unconstrained noise.
  task automatic queue_random_requests(int unsigned count);
    logic [31:0] digs, rank;
    logic [1:0] mode;
    longint unsigned weight, space;
    for (int k = 0; k < count; k++) begin
      mode = ($urandom_range(0, 19) == 0) ? MODE_UNDEF : 2'($urandom_range(0, 2));
      digs = $urandom;
      rank = 0;
      weight = 1;
      for (int i = 0; i < mrr_pkg::MAX_DIGITS; i++) begin
        case ($urandom_range(0, 3))
          0: digs[8*i +: 8] = 8'(radix_at(i) - 1);
          1: digs[8*i +: 8] = 8'd0;
          2: digs[8*i +: 8] = 8'($urandom_range(0, 32'(radix_at(i) - 1)));
          default: ;
        endcase
        if (i < digits_in_use()) rank = 32'(rank + digs[8*i +: 8] % radix_at(i) * weight);
        weight *= radix_at(i);
      end
      space = weight;
      case ($urandom_range(0, 5))
        0: rank = $urandom;
        1: rank = 32'hFFFF_FFFF - $urandom_range(0, 300);
        2: rank = (space > 0) ? 32'(rank + space * $urandom_range(0, 3)) : rank;
        default: ;
      endcase
      queue_request(mode, rank, digs, 4'($urandom));
    end
  endtask

  // Lets every outstanding transaction come back and the chain empty out.
  task automatic wait_until_idle();
    wait (pending_requests.size() == 0 && !in_valid && expected_answers.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    num_vars_shadow = 3'd4;
    for (int i = 0; i < mrr_pkg::MAX_DIGITS; i++) domain_shadow[i] = 9'd2;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed checks under the reset radices: extremes, every operation, wrap-around.
    queue_request(mrr_pkg::MODE_RANK, 32'd0, 32'h0, 4'h0);
    queue_request(mrr_pkg::MODE_RANK, 32'd0, 32'hFFFF_FFFF, 4'h0);
    queue_request(mrr_pkg::MODE_RANK, 32'd0, 32'h0101_0101, 4'hF);
    queue_request(mrr_pkg::MODE_UNRANK, 32'd0, 32'd0, 4'h0);
    queue_request(mrr_pkg::MODE_UNRANK, 32'hFFFF_FFFF, 32'd0, 4'h0);
    queue_request(mrr_pkg::MODE_UNRANK, 32'd11, 32'd0, 4'h0);
    queue_request(mrr_pkg::MODE_NEXT, 32'd15, 32'd0, 4'hF);
    queue_request(mrr_pkg::MODE_NEXT, 32'd15, 32'd0, 4'h0);
    queue_request(mrr_pkg::MODE_NEXT, 32'd5, 32'd0, 4'hA);
    queue_request(mrr_pkg::MODE_NEXT, 32'd7, 32'd0, 4'h8);
    queue_request(mrr_pkg::MODE_NEXT, 32'hFFFF_FFFF, 32'd0, 4'hF);
    queue_request(MODE_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF);
    queue_random_requests(60);
    wait_until_idle();
    phases_run++;

    // Settings: extremes of radix, out-of-range counts and radices, and mixed ones.
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: configure(4, 256, 256, 256, 256);
        1: configure(1, 256, 3, 3, 3);
        2: configure(4, 1, 1, 1, 1);
        3: configure(0, 0, 300, 3, 5);
        4: configure(7, 511, 7, 10, 13);
        5: configure(2, 3, 5, 256, 0);
        6: configure(5, 10, 256, 1, 200);
        7: configure($urandom_range(1, 4), $urandom_range(1, 256), $urandom_range(1, 256),
                     $urandom_range(1, 256), $urandom_range(1, 256));
        default: configure(3, 255, 2, 129, 6);
      endcase
      if (p == 8) idling_enabled = 1'b0;
      queue_random_requests(60);
      wait_until_idle();
      phases_run++;
    end

    $display("Covered %0d transactions in %0d radix settings, all modes included.",
             requests_sent, phases_run);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Overall time limit.
  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding.", expected_answers.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: filelist.f
rtl/mrr_pkg.sv
rtl/mrr_div_cell.sv
rtl/mrr_step_cell.sv
rtl/mrr_mac_cell.sv
rtl/mixed_radix_rank_unit_core.sv
rtl/mrr_checker.sv
verif/tb_mixed_radix_rank_unit_core.sv
